// ===== src/trp_pkg.sv =====
package trp_pkg;

    localparam int DataW = 8;
    localparam int ValueW = 64;

    // Byte classification codes.
    localparam logic [2:0] KIND_CMD      = 3'd0;
    localparam logic [2:0] KIND_STATUS   = 3'd1;
    localparam logic [2:0] KIND_ID       = 3'd2;
    localparam logic [2:0] KIND_LEN      = 3'd3;
    localparam logic [2:0] KIND_VALUE    = 3'd4;
    localparam logic [2:0] KIND_TRAILING = 3'd5;

    // End-of-payload status codes.
    localparam logic [1:0] CODE_OK        = 2'd0;
    localparam logic [1:0] CODE_SHORT     = 2'd1;
    localparam logic [1:0] CODE_TRUNCATED = 2'd2;

    // Largest value length that still fits the accumulator, in bytes.
    localparam logic [7:0] FIT_BYTES = 8'(ValueW / 8);

    typedef struct packed {
        logic [DataW-1:0] in_byte;
        logic             final_byte;
    } trp_item_t;

    typedef struct packed {
        logic [2:0]        byte_kind;
        logic [7:0]        entry_id;
        logic [7:0]        value_offset;
        logic [7:0]        out_byte;
        logic              entry_done;
        logic [ValueW-1:0] entry_value;
        logic              value_fits;
        logic              payload_done;
        logic [1:0]        parse_code;
        logic [7:0]        entry_total;
    } trp_result_t;

endpackage

// ===== src/trp_in_stage.sv =====
module trp_in_stage
    import trp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  trp_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output trp_item_t out_item
);

    logic      valid_reg;
    trp_item_t item_reg;

    // The register may take a new item whenever it is empty or drains this cycle.
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

endmodule

// ===== src/trp_parser.sv =====
module trp_parser
    import trp_pkg::*;
#(
    parameter logic [7:0] ENTRY_LIMIT = 8'd255
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        advance,
    input  trp_item_t   item,
    output trp_result_t result
);

    typedef enum logic [2:0] {
        PH_CMD    = 3'd0,
        PH_STATUS = 3'd1,
        PH_ID     = 3'd2,
        PH_LEN    = 3'd3,
        PH_VALUE  = 3'd4
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [7:0]         current_id_reg, current_id_next;
    logic [7:0]         bytes_left_reg, bytes_left_next;
    logic [7:0]         entry_length_reg, entry_length_next;
    logic [7:0]         value_index_reg, value_index_next;
    logic [ValueW-1:0]  accumulator_reg, accumulator_next;
    logic [7:0]         entry_counter_reg, entry_counter_next;

    logic [7:0] b;
    logic       fin;
    logic       complete;
    logic [7:0] bytes_dec;
    logic [1:0] code;

    assign b         = item.in_byte;
    assign fin       = item.final_byte;
    assign bytes_dec = bytes_left_reg - 8'd1;

    always_comb begin
        phase_next         = phase_reg;
        current_id_next    = current_id_reg;
        bytes_left_next    = bytes_left_reg;
        entry_length_next  = entry_length_reg;
        value_index_next   = value_index_reg;
        accumulator_next   = accumulator_reg;
        complete           = 1'b0;
        code               = CODE_OK;

        result              = '0;
        result.out_byte     = b;
        result.payload_done = fin;

        unique case (phase_reg)
            PH_STATUS: begin
                result.byte_kind = KIND_STATUS;
                phase_next       = PH_ID;
            end
            PH_ID: begin
                if (fin) begin
                    result.byte_kind = KIND_TRAILING;
                end else begin
                    result.byte_kind = KIND_ID;
                    result.entry_id  = b;
                    current_id_next  = b;
                    phase_next       = PH_LEN;
                end
            end
            PH_LEN: begin
                result.byte_kind  = KIND_LEN;
                result.entry_id   = current_id_reg;
                entry_length_next = b;
                if (b == 8'd0) begin
                    // An empty entry completes on its length byte.
                    complete   = 1'b1;
                    phase_next = PH_ID;
                end else begin
                    bytes_left_next  = b;
                    value_index_next = 8'd0;
                    accumulator_next = '0;
                    phase_next       = PH_VALUE;
                    if (fin) begin
                        code = CODE_TRUNCATED;
                    end
                end
            end
            PH_VALUE: begin
                result.byte_kind    = KIND_VALUE;
                result.entry_id     = current_id_reg;
                result.value_offset = value_index_reg;
                accumulator_next    = {accumulator_reg[ValueW-9:0], b};
                value_index_next    = value_index_reg + 8'd1;
                bytes_left_next     = bytes_dec;
                if (bytes_dec == 8'd0) begin
                    complete   = 1'b1;
                    phase_next = PH_ID;
                    if (entry_length_reg >= 8'd1 && entry_length_reg <= FIT_BYTES) begin
                        result.value_fits  = 1'b1;
                        result.entry_value = accumulator_next;
                    end
                end else if (fin) begin
                    code = CODE_TRUNCATED;
                end
            end
            default: begin
                result.byte_kind = KIND_CMD;
                phase_next       = PH_STATUS;
                if (fin) begin
                    code = CODE_SHORT;
                end
            end
        endcase

        entry_counter_next = entry_counter_reg;
        if (complete && entry_counter_reg < ENTRY_LIMIT) begin
            entry_counter_next = entry_counter_reg + 8'd1;
        end

        result.entry_done  = complete;
        result.parse_code  = fin ? code : CODE_OK;
        result.entry_total = entry_counter_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_CMD;
            current_id_reg    <= '0;
            bytes_left_reg    <= '0;
            entry_length_reg  <= '0;
            value_index_reg   <= '0;
            accumulator_reg   <= '0;
            entry_counter_reg <= '0;
        end else if (advance) begin
            if (fin) begin
                // The payload ends here, so the parser starts over.
                phase_reg         <= PH_CMD;
                current_id_reg    <= '0;
                bytes_left_reg    <= '0;
                entry_length_reg  <= '0;
                value_index_reg   <= '0;
                accumulator_reg   <= '0;
                entry_counter_reg <= '0;
            end else begin
                phase_reg         <= phase_next;
                current_id_reg    <= current_id_next;
                bytes_left_reg    <= bytes_left_next;
                entry_length_reg  <= entry_length_next;
                value_index_reg   <= value_index_next;
                accumulator_reg   <= accumulator_next;
                entry_counter_reg <= entry_counter_next;
            end
        end
    end

endmodule

// ===== src/trp_out_stage.sv =====
module trp_out_stage
    import trp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  trp_result_t in_result,
    output logic        out_valid,
    input  logic        out_ready,
    output trp_result_t out_result
);

    logic        valid_reg;
    trp_result_t result_reg;

    assign in_ready   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            result_reg <= in_result;
        end
    end

endmodule

// ===== src/tlv_response_parser_unit.sv =====
// Type-length-value response parser. Each payload byte enters on s_tdata with s_tlast on
// its final byte; one result item per byte leaves on the master side, classifying the
// byte, naming its entry, reporting completed entries with their big-endian value and
// the saturating entry count, and giving the parse status on the final byte. The block
// takes one byte per clock cycle when the result side keeps up; a result passes through
// the input register and then the result register before it is offered on the master
// side. The parser between the two updates its state once per byte, which sets that
// rate.
module tlv_response_parser_unit
    import trp_pkg::*;
#(
    parameter int MAX_ENTRIES = 255
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] in_byte
    input  logic         s_tlast,   // final_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    // [7:0] entry_id, [15:8] value_offset, [23:16] out_byte, [24] entry_done,
    // [88:25] entry_value, [89] value_fits, [91:90] parse_code, [99:92] entry_total,
    // [103:100] zero
    output logic [103:0] m_tdata,
    output logic [2:0]   m_tuser,   // [2:0] byte_kind
    output logic         m_tlast    // payload_done
);

    localparam logic [7:0] EntryLimit = 8'((MAX_ENTRIES > 255) ? 255 : MAX_ENTRIES);

    trp_item_t   s_item;
    trp_item_t   held_item;
    logic        held_valid;
    logic        step_ready;
    trp_result_t step_result;
    trp_result_t m_result;

    assign s_item.in_byte    = s_tdata;
    assign s_item.final_byte = s_tlast;

    trp_in_stage u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (s_item),
        .out_valid (held_valid),
        .out_ready (step_ready),
        .out_item  (held_item)
    );

    trp_parser #(
        .ENTRY_LIMIT (EntryLimit)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (held_valid && step_ready),
        .item    (held_item),
        .result  (step_result)
    );

    trp_out_stage u_out_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (held_valid),
        .in_ready   (step_ready),
        .in_result  (step_result),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (m_result)
    );

    assign m_tdata = {4'd0,
                      m_result.entry_total,
                      m_result.parse_code,
                      m_result.value_fits,
                      m_result.entry_value,
                      m_result.entry_done,
                      m_result.out_byte,
                      m_result.value_offset,
                      m_result.entry_id};
    assign m_tuser = m_result.byte_kind;
    assign m_tlast = m_result.payload_done;

endmodule
